@@ src/proj_pkg.sv @@
// Shared types, widths and register codes for the vertex projection pipeline.
// No dependencies; every other file imports this package.
package proj_pkg;

  localparam int COEF_FRAC  = 12;            // Q4.12 fraction bits
  localparam int POINT_FRAC = 16;            // Q16.16 fraction bits

  localparam int PT_W    = 32;               // Q16.16 point coordinate
  localparam int CF_W    = 16;               // Q4.12 matrix coefficient
  localparam int H_W     = PT_W + CF_W + 2;  // clip coordinate, four-term sum
  localparam int VW_W    = H_W + 1;          // clip value plus clip w
  localparam int VP_W    = 16;               // viewport origin / size field
  localparam int OR_W    = VP_W + 1;         // 2 * origin + 1
  localparam int SPLIT   = 26;               // low part of a split multiply
  localparam int NUM_W   = VW_W + VP_W + 3;  // signed window numerator
  localparam int DEN_W   = H_W + 1;          // 2 * |w|
  localparam int QB      = 16;               // quotient bits before saturation
  localparam int SCR_W   = 16;

  localparam int MV_LAT  = 2;
  localparam int NUM_LAT = 3;
  localparam int DIV_LAT = QB + 2;
  localparam int LATENCY = MV_LAT + NUM_LAT + DIV_LAT;

  localparam logic [2:0] REG_ROW0      = 3'd0;
  localparam logic [2:0] REG_ROW1      = 3'd1;
  localparam logic [2:0] REG_ROW2      = 3'd2;
  localparam logic [2:0] REG_ROW3      = 3'd3;
  localparam logic [2:0] REG_VP_ORIGIN = 3'd4;
  localparam logic [2:0] REG_VP_SIZE   = 3'd5;

  localparam logic [QB-1:0] POS_LIM = 16'h7fff;
  localparam logic [QB-1:0] NEG_LIM = 16'h8000;

  typedef struct packed {
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;
    logic signed [PT_W-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [SCR_W-1:0] screen_x;
    logic signed [SCR_W-1:0] screen_y;
    logic                    w_was_zero;
    logic                    clamped;
  } result_t;

  typedef struct packed {
    logic valid;
    logic wzero;
    logic neg;
  } lane_ctl_t;

endpackage

@@ src/proj_matvec.sv @@
// Two-stage matrix-vector product: clip x, y and w of a homogeneous point.
// Depends on proj_pkg.
module proj_matvec #(
  parameter int POINT_FRAC_BITS = proj_pkg::POINT_FRAC
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             valid_in,
  input  proj_pkg::point_t                 point,
  input  logic [3:0][63:0]                 rows,
  output logic                             valid_out,
  output logic signed [proj_pkg::H_W-1:0]  h_x,
  output logic signed [proj_pkg::H_W-1:0]  h_y,
  output logic signed [proj_pkg::H_W-1:0]  h_w
);
  import proj_pkg::*;

  localparam int P_W = PT_W + CF_W;

  logic signed [PT_W-1:0] pt [3];
  logic signed [P_W-1:0]  prod [3][3];
  logic signed [H_W-1:0]  h [3];
  logic                   valid1;

  assign pt[0] = point.point_x;
  assign pt[1] = point.point_y;
  assign pt[2] = point.point_z;

  genvar l, c;
  for (l = 0; l < 3; l++) begin : g_row
    // lane 2 is matrix row three; row two is not used here
    localparam int R = (l == 2) ? 3 : l;
    logic signed [CF_W-1:0] bias;
    logic signed [H_W-1:0]  sum;
    assign bias = $signed(rows[R][4*CF_W-1 -: CF_W]);
    for (c = 0; c < 3; c++) begin : g_col
      logic signed [CF_W-1:0] coef;
      assign coef = $signed(rows[R][c*CF_W +: CF_W]);
      always_ff @(posedge clk) begin
        prod[l][c] <= P_W'(coef * pt[c]);
      end
    end
    always_comb begin
      sum = H_W'(prod[l][0]) + H_W'(prod[l][1]) + H_W'(prod[l][2])
          + (H_W'(bias) <<< POINT_FRAC_BITS);
    end
    always_ff @(posedge clk) begin
      h[l] <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1    <= 1'b0;
      valid_out <= 1'b0;
    end else begin
      valid1    <= valid_in;
      valid_out <= valid1;
    end
  end

  assign h_x = h[0];
  assign h_y = h[1];
  assign h_w = h[2];

endmodule

@@ src/proj_numer.sv @@
// Three-stage window numerator ((2o+1)w + size(v+w)) and denominator 2|w|
// for both screen axes. Depends on proj_pkg.
module proj_numer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              valid_in,
  input  logic signed [proj_pkg::H_W-1:0]   h_x,
  input  logic signed [proj_pkg::H_W-1:0]   h_y,
  input  logic signed [proj_pkg::H_W-1:0]   h_w,
  input  logic [31:0]                       origin,
  input  logic [31:0]                       size,
  output proj_pkg::lane_ctl_t               ctl_x,
  output proj_pkg::lane_ctl_t               ctl_y,
  output logic [proj_pkg::NUM_W-1:0]        mag_x,
  output logic [proj_pkg::NUM_W-1:0]        mag_y,
  output logic [proj_pkg::DEN_W-1:0]        den
);
  import proj_pkg::*;

  localparam int WH_W  = H_W - SPLIT;
  localparam int VH_W  = VW_W - SPLIT;
  localparam int PA_W  = OR_W + 1 + WH_W;
  localparam int PAL_W = OR_W + SPLIT;
  localparam int PB_W  = VP_W + 1 + VH_W;
  localparam int PBL_W = VP_W + SPLIT;

  // stage A
  logic                    va, wzero_a, wneg_a;
  logic [H_W-1:0]          wabs_a;
  logic signed [PA_W-1:0]  a_hi [2];
  logic [PAL_W-1:0]        a_lo [2];
  logic signed [PB_W-1:0]  b_hi [2];
  logic [PBL_W-1:0]        b_lo [2];
  // stage B
  logic                    vb, wzero_b, wneg_b;
  logic signed [NUM_W-1:0] num_b [2];
  logic [DEN_W-1:0]        den_b;
  // stage C
  lane_ctl_t               ctl_c [2];
  logic [NUM_W-1:0]        mag_c [2];
  logic [DEN_W-1:0]        den_c;

  logic signed [H_W-1:0] hv [2];
  assign hv[0] = h_x;
  assign hv[1] = h_y;

  genvar a;
  for (a = 0; a < 2; a++) begin : g_axis
    logic [VP_W-1:0]         org, sz;
    logic [OR_W-1:0]         org2;
    logic signed [VW_W-1:0]  vw;
    logic signed [NUM_W-1:0] num;
    logic                    nneg;

    assign org  = origin[a*VP_W +: VP_W];
    assign sz   = size[a*VP_W +: VP_W];
    assign org2 = {org, 1'b1};
    assign vw   = VW_W'(hv[a]) + VW_W'(h_w);

    always_ff @(posedge clk) begin
      a_lo[a] <= PAL_W'(org2) * PAL_W'(h_w[SPLIT-1:0]);
      a_hi[a] <= PA_W'($signed({1'b0, org2}) * $signed(h_w[H_W-1:SPLIT]));
      b_lo[a] <= PBL_W'(sz) * PBL_W'(vw[SPLIT-1:0]);
      b_hi[a] <= PB_W'($signed({1'b0, sz}) * $signed(vw[VW_W-1:SPLIT]));
    end

    always_comb begin
      num = (NUM_W'(a_hi[a]) <<< SPLIT) + $signed(NUM_W'(a_lo[a]))
          + (NUM_W'(b_hi[a]) <<< SPLIT) + $signed(NUM_W'(b_lo[a]));
    end

    always_ff @(posedge clk) begin
      num_b[a] <= num;
    end

    assign nneg = num_b[a][NUM_W-1];

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_c[a] <= '0;
      end else begin
        ctl_c[a].valid <= vb;
        ctl_c[a].wzero <= wzero_b;
        ctl_c[a].neg   <= nneg ^ wneg_b;
      end
      mag_c[a] <= nneg ? NUM_W'(-num_b[a]) : NUM_W'(num_b[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      va <= valid_in;
      vb <= va;
    end
    wzero_a <= (h_w == '0);
    wneg_a  <= h_w[H_W-1];
    wabs_a  <= h_w[H_W-1] ? H_W'(-h_w) : H_W'(h_w);
    wzero_b <= wzero_a;
    wneg_b  <= wneg_a;
    den_b   <= {wabs_a, 1'b0};
    den_c   <= den_b;
  end

  assign ctl_x = ctl_c[0];
  assign ctl_y = ctl_c[1];
  assign mag_x = mag_c[0];
  assign mag_y = mag_c[1];
  assign den   = den_c;

endmodule

@@ src/proj_div.sv @@
// Pipelined restoring divider for one screen axis: one quotient bit a stage,
// then sign, saturation and zero-w handling. Depends on proj_pkg.
module proj_div (
  input  logic                              clk,
  input  logic                              rst,
  input  proj_pkg::lane_ctl_t               ctl_in,
  input  logic [proj_pkg::NUM_W-1:0]        mag,
  input  logic [proj_pkg::DEN_W-1:0]        den,
  output logic                              valid,
  output logic                              wzero,
  output logic signed [proj_pkg::SCR_W-1:0] coord,
  output logic                              sat
);
  import proj_pkg::*;

  localparam int CMP_W = NUM_W + 1;

  lane_ctl_t        ctl_q [QB+1];
  logic [NUM_W-1:0] rem_q [QB+1];
  logic [DEN_W-1:0] den_q [QB+1];
  logic [QB-1:0]    q_q   [QB+1];
  logic             ovf_q [QB+1];

  // quotient of 2^QB or more saturates either way
  always_ff @(posedge clk) begin
    if (rst) ctl_q[0] <= '0;
    else     ctl_q[0] <= ctl_in;
    rem_q[0] <= mag;
    den_q[0] <= den;
    q_q[0]   <= '0;
    ovf_q[0] <= CMP_W'(mag) >= (CMP_W'(den) << QB);
  end

  genvar j;
  for (j = 1; j <= QB; j++) begin : g_step
    localparam int B = QB - j;
    logic [CMP_W-1:0] sub;
    logic             ge;
    always_comb begin
      sub = CMP_W'(den_q[j-1]) << B;
      ge  = CMP_W'(rem_q[j-1]) >= sub;
    end
    always_ff @(posedge clk) begin
      if (rst) ctl_q[j] <= '0;
      else     ctl_q[j] <= ctl_q[j-1];
      den_q[j] <= den_q[j-1];
      ovf_q[j] <= ovf_q[j-1];
      rem_q[j] <= ge ? rem_q[j-1] - sub[NUM_W-1:0] : rem_q[j-1];
      q_q[j]   <= q_q[j-1] | (QB'(ge) << B);
    end
  end

  logic [QB-1:0] q;
  logic [QB-1:0] coord_next;
  logic          sat_next;

  assign q = q_q[QB];

  always_comb begin
    coord_next = '0;
    sat_next   = 1'b0;
    priority if (ctl_q[QB].wzero) begin
      coord_next = '0;
    end else if (ctl_q[QB].neg) begin
      if (ovf_q[QB] || q > NEG_LIM) begin
        coord_next = NEG_LIM;
        sat_next   = 1'b1;
      end else begin
        coord_next = QB'(-q);
      end
    end else begin
      if (ovf_q[QB] || q > POS_LIM) begin
        coord_next = POS_LIM;
        sat_next   = 1'b1;
      end else begin
        coord_next = q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) valid <= 1'b0;
    else     valid <= ctl_q[QB].valid;
    wzero <= ctl_q[QB].wzero;
    coord <= $signed(coord_next);
    sat   <= sat_next;
  end

endmodule

@@ src/vertex_world_to_screen_projection_unit.sv @@
// Top level of the vertex world-to-window projection: config registers,
// matrix product, numerator, two divider lanes. Depends on proj_pkg and all
// proj_* modules.
//
//   channel  | ports                         | transfer
//   ---------+-------------------------------+------------------------------
//   point in | start, busy, point            | edge with start & !busy
//   result   | done, result                  | every edge with done high
//   config   | wr_en, wr_index, wr_data      | every edge with wr_en high
//
// A point is taken every cycle while busy is low; its result passes through
// the matrix product, the numerator and the one-bit-a-stage divider in turn.
// busy is high during reset and in the first cycle after it. The receiver
// cannot stall, so the pipeline never holds; reset flushes all valid bits.
module vertex_world_to_screen_projection_unit #(
  parameter int COEF_FRAC_BITS  = proj_pkg::COEF_FRAC,
  parameter int POINT_FRAC_BITS = proj_pkg::POINT_FRAC
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  proj_pkg::point_t  point,
  output logic              done,
  output proj_pkg::result_t result,
  input  logic              wr_en,
  input  logic [2:0]        wr_index,
  input  logic [63:0]       wr_data
);
  import proj_pkg::*;

  logic [3:0][63:0] rows;
  logic [31:0]      vp_origin;
  logic [31:0]      vp_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows[0]   <= 64'(1) << COEF_FRAC_BITS;
      rows[1]   <= 64'(1) << (COEF_FRAC_BITS + 16);
      rows[2]   <= 64'(1) << (COEF_FRAC_BITS + 32);
      rows[3]   <= 64'(1) << (COEF_FRAC_BITS + 48);
      vp_origin <= '0;
      vp_size   <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_ROW0:      rows[0]   <= wr_data;
        REG_ROW1:      rows[1]   <= wr_data;
        REG_ROW2:      rows[2]   <= wr_data;
        REG_ROW3:      rows[3]   <= wr_data;
        REG_VP_ORIGIN: vp_origin <= wr_data[31:0];
        REG_VP_SIZE:   vp_size   <= wr_data[31:0];
        default:       ;  // drop writes past the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  logic                  mv_valid;
  logic signed [H_W-1:0] h_x, h_y, h_w;

  proj_matvec #(
    .POINT_FRAC_BITS(POINT_FRAC_BITS)
  ) u_matvec (
    .clk       (clk),
    .rst       (rst),
    .valid_in  (start & ~busy),
    .point     (point),
    .rows      (rows),
    .valid_out (mv_valid),
    .h_x       (h_x),
    .h_y       (h_y),
    .h_w       (h_w)
  );

  lane_ctl_t        ctl_x, ctl_y;
  logic [NUM_W-1:0] mag_x, mag_y;
  logic [DEN_W-1:0] den;

  proj_numer u_numer (
    .clk      (clk),
    .rst      (rst),
    .valid_in (mv_valid),
    .h_x      (h_x),
    .h_y      (h_y),
    .h_w      (h_w),
    .origin   (vp_origin),
    .size     (vp_size),
    .ctl_x    (ctl_x),
    .ctl_y    (ctl_y),
    .mag_x    (mag_x),
    .mag_y    (mag_y),
    .den      (den)
  );

  logic                    vx, vy, wz_x, wz_y, sat_x, sat_y;
  logic signed [SCR_W-1:0] sx, sy;

  proj_div u_div_x (
    .clk    (clk),
    .rst    (rst),
    .ctl_in (ctl_x),
    .mag    (mag_x),
    .den    (den),
    .valid  (vx),
    .wzero  (wz_x),
    .coord  (sx),
    .sat    (sat_x)
  );

  proj_div u_div_y (
    .clk    (clk),
    .rst    (rst),
    .ctl_in (ctl_y),
    .mag    (mag_y),
    .den    (den),
    .valid  (vy),
    .wzero  (wz_y),
    .coord  (sy),
    .sat    (sat_y)
  );

  assign done              = vx;
  assign result.screen_x   = sx;
  assign result.screen_y   = sy;
  assign result.w_was_zero = wz_x;
  assign result.clamped    = sat_x | sat_y;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("result missing after point transfer");

  a_lanes_agree: assert property (@(posedge clk) disable iff (rst)
    vx == vy && (!vx || wz_x == wz_y))
    else $error("divider lanes out of step");

  a_zero_w: assert property (@(posedge clk) disable iff (rst)
    (done && result.w_was_zero) |->
      (result.screen_x == 0 && result.screen_y == 0 && !result.clamped))
    else $error("zero w result not cleared");

  a_clamp_value: assert property (@(posedge clk) disable iff (rst)
    (done && result.clamped) |->
      (result.screen_x == 16'sh7fff || result.screen_x == -16'sh8000 ||
       result.screen_y == 16'sh7fff || result.screen_y == -16'sh8000))
    else $error("clamp flag without saturated coordinate");
`endif

endmodule
